/* hdl/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants and types for the text console writer
// Screen geometry, character codes, function codes and the command and
// status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;

  // port widths
  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ADDR_W = 11;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  typedef struct packed {
    logic load;
    logic put_wr;
    logic scroll_rd;
    logic tail;
    logic fill;
    logic rd_cap;
    logic finish;
  } tcw_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic scroll_need;
    logic out_free;
  } tcw_sts_t;

endpackage
`default_nettype wire

/* hdl/tcw_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/tcw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, cell store, sweep counter and result register
// Executes the controller's commands; reports sweep end, scroll and
// result-register status.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tcw_pkg::tcw_cmd_t              cmd,
  output tcw_pkg::tcw_sts_t                   sts,
  input  wire logic [tcw_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     in_fill_attribute,
  input  wire logic [tcw_pkg::RROW_W-1:0]     in_read_row,
  input  wire logic [tcw_pkg::RCOL_W-1:0]     in_read_col,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic      [tcw_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  output logic      [tcw_pkg::OUT_COL_W-1:0]  out_cursor_col,
  output logic      [tcw_pkg::OUT_ADDR_W-1:0] out_cursor_address,
  output logic      [tcw_pkg::CELL_W-1:0]     out_cell_data
);
  import tcw_pkg::*;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic              copy_vld_r;
  logic [ADDR_W-1:0] copy_addr_r;
  logic [CHAR_W-1:0] ch_r;
  logic              rd_ok_r;
  logic [CELL_W-1:0] cell_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_ROW_W-1:0]  out_row_r;
  logic [OUT_COL_W-1:0]  out_col_r;
  logic [OUT_ADDR_W-1:0] out_addr_r;
  logic [CELL_W-1:0]     out_cell_r;

  logic              in_ok;
  logic [ADDR_W-1:0] in_lin;
  logic [ADDR_W-1:0] cur_lin;
  logic              is_nl, is_bs, is_tab, put_writes;
  logic [CHAR_W-1:0] put_ch;
  logic [COL_W:0]    col_adv;
  logic [ROW_W:0]    row_adv, row_wrap;
  logic [COL_W-1:0]  col_fin;
  logic [ROW_W-1:0]  row_fin;
  logic              scroll_need;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  assign in_ok  = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS);
  assign in_lin = ADDR_W'(ADDR_W'(in_read_row) * ADDR_W'(COLUMNS) + ADDR_W'(in_read_col));
  assign cur_lin = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r));

  // put character: cursor advance, wrap and scroll detection
  always_comb begin
    is_nl      = (ch_r == CH_NEWLINE);
    is_bs      = (ch_r == CH_BACKSPACE);
    is_tab     = (ch_r == CH_TAB);
    put_writes = !is_nl && !is_bs;
    put_ch     = is_tab ? CH_SPACE : ch_r;
    if (is_nl) begin
      col_adv = '0;
      row_adv = {1'b0, row_r} + {{ROW_W{1'b0}}, 1'b1};
    end else if (is_bs) begin
      col_adv = {1'b0, col_r};
      row_adv = {1'b0, row_r};
    end else begin
      col_adv = {1'b0, col_r} + {{COL_W{1'b0}}, 1'b1};
      row_adv = {1'b0, row_r};
    end
    if (int'(col_adv) >= COLUMNS) begin
      col_fin  = '0;
      row_wrap = row_adv + {{ROW_W{1'b0}}, 1'b1};
    end else begin
      col_fin  = col_adv[COL_W-1:0];
      row_wrap = row_adv;
    end
    scroll_need = int'(row_wrap) >= ROWS;
    row_fin     = scroll_need ? ROW_W'(ROWS - 1) : row_wrap[ROW_W-1:0];
  end

  // cell store ports
  always_comb begin
    if (cmd.scroll_rd) begin
      raddr = cnt_r;
    end else if (in_func == FN_READ) begin
      raddr = in_ok ? in_lin : '0;
    end else begin
      raddr = cur_lin;
    end
    we = copy_vld_r || cmd.fill || (cmd.put_wr && put_writes);
    if (copy_vld_r) begin
      waddr = copy_addr_r;
      wdata = rdata;
    end else if (cmd.fill) begin
      waddr = cnt_r;
      wdata = fill_val_r;
    end else begin
      waddr = cur_lin;
      wdata = {rdata[CELL_W-1:CHAR_W], put_ch};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    fill_val_nxt = fill_val_r;
    if (cmd.load && in_func == FN_CLEAR) begin
      row_nxt      = '0;
      col_nxt      = '0;
      cnt_nxt      = '0;
      fill_val_nxt = {in_fill_attribute, in_char_code};
    end
    if (cmd.put_wr) begin
      row_nxt = row_fin;
      col_nxt = col_fin;
      if (scroll_need) begin
        cnt_nxt = ADDR_W'(COLUMNS);
      end
    end
    if (cmd.scroll_rd || cmd.fill) begin
      cnt_nxt = cnt_r + {{(ADDR_W-1){1'b0}}, 1'b1};
    end
    if (cmd.tail) begin
      cnt_nxt      = ADDR_W'((ROWS - 1) * COLUMNS);
      fill_val_nxt = BLANK_CELL;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      fill_val_r  <= BLANK_CELL;
      copy_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      copy_vld_r  <= cmd.scroll_rd;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_addr_r <= cnt_r - ADDR_W'(COLUMNS);
    if (cmd.load) begin
      ch_r    <= in_char_code;
      rd_ok_r <= (in_func == FN_READ) && in_ok;
      cell_r  <= '0;
    end
    if (cmd.rd_cap && rd_ok_r) begin
      cell_r <= rdata;
    end
    if (cmd.finish) begin
      out_row_r  <= OUT_ROW_W'(row_r);
      out_col_r  <= OUT_COL_W'(col_r);
      out_addr_r <= OUT_ADDR_W'(cur_lin);
      out_cell_r <= cell_r;
    end
  end

  assign sts.cnt_last    = (int'(cnt_r) == CELL_COUNT - 1);
  assign sts.scroll_need = scroll_need;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_col     = out_col_r;
  assign out_cursor_address = out_addr_r;
  assign out_cell_data      = out_cell_r;

endmodule
`default_nettype wire

/* hdl/tcw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing state machine
// Start-up blanking sweep, word acceptance, put, scroll copy, fills, cell
// reads and hand-off to the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [tcw_pkg::FUNC_W-1:0] in_func,
  output logic                            in_stall,
  output tcw_pkg::tcw_cmd_t               cmd,
  input  wire tcw_pkg::tcw_sts_t          sts
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_SCRL = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_RDC  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_INIT: begin
        cmd.fill = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_func)
            FN_PUT:   state_nxt = S_PUT;
            FN_CLEAR: state_nxt = S_FILL;
            FN_READ:  state_nxt = S_RDC;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        cmd.put_wr = 1'b1;
        state_nxt  = sts.scroll_need ? S_SCRL : S_DONE;
      end
      S_SCRL: begin
        cmd.scroll_rd = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_RDC: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/text_console_writer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cell store and cursor
// Puts characters with wrap and scroll, clears the screen, reads cells.
//
//   channel  ports                                        direction
//   in_      valid, stall, func, char_code, fill_attribute,
//            read_row, read_col                           word in
//   out_     valid, stall, cursor_row, cursor_col,
//            cursor_address, cell_data                    word out
//
// A scroll copies rows 1 to ROWS-1 up one row through the single write port
// of the cell store, then blanks the bottom row; clear fills every cell.
// After reset a blanking sweep over all CELL_COUNT cells runs with in_stall high.
// A stalled result waits in the output register; the next word is taken
// meanwhile and held finished until that register frees.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tcw_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [tcw_pkg::ATTR_W-1:0]     in_fill_attribute,
  input  wire logic [tcw_pkg::RROW_W-1:0]     in_read_row,
  input  wire logic [tcw_pkg::RCOL_W-1:0]     in_read_col,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tcw_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  output logic      [tcw_pkg::OUT_COL_W-1:0]  out_cursor_col,
  output logic      [tcw_pkg::OUT_ADDR_W-1:0] out_cursor_address,
  output logic      [tcw_pkg::CELL_W-1:0]     out_cell_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  tcw_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_char_code       (in_char_code),
    .in_fill_attribute  (in_fill_attribute),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_address (out_cursor_address),
    .out_cell_data      (out_cell_data)
  );

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text console writer
// A scoreboard keeps its own copy of the screen and cursor, works out the
// status word each accepted command should give and checks every returned
// word field by field. Directed commands first, then random lines of text
// with wraps, scrolls, clears and reads, under varying stall and idle load.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 950;
  localparam int CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [OUT_ROW_W-1:0]  row;
    logic [OUT_COL_W-1:0]  col;
    logic [OUT_ADDR_W-1:0] addr;
    logic [CELL_W-1:0]     data;
  } console_status_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    console_status_t   status_q [$];
    int                mismatches;
    int                n_puts, n_scrolls, n_clears, n_reads, n_off_reads, n_unused;

    function new();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cur_row = 0;
      cur_col = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_word(logic [FUNC_W-1:0] fn, logic [CHAR_W-1:0] ch,
                            logic [ATTR_W-1:0] attr, logic [RROW_W-1:0] rr,
                            logic [RCOL_W-1:0] rc);
      console_status_t st;
      int              idx;
      st.data = '0;
      case (fn)
        FN_PUT: begin
          n_puts++;
          if (ch == CH_NEWLINE) begin
            cur_row++;
            cur_col = 0;
          end else if (ch != CH_BACKSPACE) begin
            idx = cur_row * COLUMNS + cur_col;
            screen[idx][CHAR_W-1:0] = (ch == CH_TAB) ? CH_SPACE : ch;
            cur_col++;
          end
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
          if (cur_row >= ROWS) begin
            for (int i = COLUMNS; i < CELL_COUNT; i++) screen[i-COLUMNS] = screen[i];
            for (int i = (ROWS-1)*COLUMNS; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
            cur_row = ROWS - 1;
            n_scrolls++;
          end
        end
        FN_CLEAR: begin
          n_clears++;
          foreach (screen[i]) screen[i] = {attr, ch};
          cur_row = 0;
          cur_col = 0;
        end
        FN_READ: begin
          n_reads++;
          if (rr < ROWS && rc < COLUMNS) st.data = screen[rr*COLUMNS + rc];
          else n_off_reads++;
        end
        default: n_unused++;
      endcase
      st.row  = cur_row[OUT_ROW_W-1:0];
      st.col  = cur_col[OUT_COL_W-1:0];
      idx     = cur_row * COLUMNS + cur_col;
      st.addr = idx[OUT_ADDR_W-1:0];
      status_q.push_back(st);
    endfunction

    function void check_word(console_status_t got);
      console_status_t want;
      if (status_q.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected word row=%0d col=%0d addr=%0d cell=%h",
                   got.row, got.col, got.addr, got.data);
        mismatches++;
        return;
      end
      want = status_q.pop_front();
      if (want != got) begin
        if (mismatches < 10)
          $display({"ERROR: exp row=%0d col=%0d addr=%0d cell=%h, ",
                    "got row=%0d col=%0d addr=%0d cell=%h"},
                   want.row, want.col, want.addr, want.data,
                   got.row, got.col, got.addr, got.data);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func = FN_PUT;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic [ATTR_W-1:0]     in_fill_attribute = '0;
  logic [RROW_W-1:0]     in_read_row = '0;
  logic [RCOL_W-1:0]     in_read_col = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_ROW_W-1:0]  out_cursor_row;
  logic [OUT_COL_W-1:0]  out_cursor_col;
  logic [OUT_ADDR_W-1:0] out_cursor_address;
  logic [CELL_W-1:0]     out_cell_data;

  console_scoreboard sb = new();
  int                snd_idle_pct = 29;
  int                rcv_stall_pct = 86;
  int                cycles = 0;
  int                words_sent = 0;

  text_console_writer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_char_code       (in_char_code),
    .in_fill_attribute  (in_fill_attribute),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_address (out_cursor_address),
    .out_cell_data      (out_cell_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word({out_cursor_row, out_cursor_col, out_cursor_address, out_cell_data});
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(logic [FUNC_W-1:0] fn, logic [CHAR_W-1:0] ch,
                           logic [ATTR_W-1:0] attr, logic [RROW_W-1:0] rr,
                           logic [RCOL_W-1:0] rc);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= fn;
    in_char_code      <= ch;
    in_fill_attribute <= attr;
    in_read_row       <= rr;
    in_read_col       <= rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(fn, ch, attr, rr, rc);
    words_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // one random word from the body of a line of text
  task automatic send_text_word;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    int                pick;
    ch   = CHAR_W'($urandom_range(0, 255));
    attr = ATTR_W'($urandom_range(0, 255));
    rr   = RROW_W'($urandom_range(0, 31));
    rc   = RCOL_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 72) send_word(FN_PUT, ch, attr, rr, rc);
    else if (pick < 77) send_word(FN_PUT, CH_TAB, attr, rr, rc);
    else if (pick < 81) send_word(FN_PUT, CH_BACKSPACE, attr, rr, rc);
    else if (pick < 95) begin
      if ($urandom_range(0, 99) < 85) begin
        rr = RROW_W'($urandom_range(0, ROWS - 1));
        rc = RCOL_W'($urandom_range(0, COLUMNS - 1));
      end
      send_word(FN_READ, ch, attr, rr, rc);
    end else send_word(FN_UNUSED, ch, attr, rr, rc);
  endtask

  // a line: short or long enough to wrap, ending in a newline; now and then a clear
  task automatic send_segment;
    int len;
    if ($urandom_range(0, 29) == 0) begin
      send_word(FN_CLEAR, CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)),
                RROW_W'($urandom_range(0, 31)), RCOL_W'($urandom_range(0, 127)));
      return;
    end
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(75, 165) : $urandom_range(0, 15);
    repeat (len) send_text_word();
    send_word(FN_PUT, CH_NEWLINE, ATTR_W'($urandom_range(0, 255)),
              RROW_W'($urandom_range(0, 31)), RCOL_W'($urandom_range(0, 127)));
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    send_word(FN_PUT, 8'h41, 8'h00, 5'd0, 7'd0);
    send_word(FN_PUT, 8'h00, 8'hFF, 5'd31, 7'd127);
    send_word(FN_PUT, 8'hFF, 8'h00, 5'd0, 7'd0);
    send_word(FN_PUT, CH_TAB, 8'h00, 5'd0, 7'd0);
    send_word(FN_PUT, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd3);
    send_word(FN_PUT, CH_NEWLINE, 8'h00, 5'd0, 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, RROW_W'(ROWS), 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, 5'd31, 7'd127);
    send_word(FN_READ, 8'h00, 8'h00, 5'd0, RCOL_W'(COLUMNS));
    send_word(FN_READ, 8'h00, 8'h00, RROW_W'(ROWS - 1), RCOL_W'(COLUMNS - 1));
    send_word(FN_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_word(FN_CLEAR, 8'hFF, 8'hFF, 5'd0, 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, RROW_W'(ROWS - 1), RCOL_W'(COLUMNS - 1));
    send_word(FN_PUT, 8'h5A, 8'h00, 5'd0, 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd0);
    send_word(FN_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_word(FN_READ, 8'h00, 8'h00, 5'd12, 7'd40);

    target = words_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 29; rcv_stall_pct = 86; end
        1: begin snd_idle_pct = 86; rcv_stall_pct = 29; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      target += RANDOM_WORDS / 3;
      while (words_sent < target) send_segment();
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d words: %0d puts, %0d scrolls, %0d clears, %0d reads (%0d off screen)",
             words_sent, sb.n_puts, sb.n_scrolls, sb.n_clears, sb.n_reads, sb.n_off_reads);
    $display("%0d unused-code words, %0d mismatches, %0d cycles",
             sb.n_unused, sb.mismatches, cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
